// ----- rtl/backlight_level_to_pwm_duty_assert.svh -----
// ----------------------------------------------------------------------------
// backlight level to pwm duty: assertion macros
// shared property forms for the checker, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef BACKLIGHT_LEVEL_TO_PWM_DUTY_ASSERT_SVH
`define BACKLIGHT_LEVEL_TO_PWM_DUTY_ASSERT_SVH

// same-cycle implication
`define BLPD_AST_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("blpd assertion failed");

// next-cycle implication
`define BLPD_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("blpd assertion failed");

`endif

// ----- rtl/blpd_pkg.sv -----
// ----------------------------------------------------------------------------
// blpd_pkg
// types, register indexes and brightness curves for the backlight duty block
// ----------------------------------------------------------------------------
package blpd_pkg;

	typedef struct packed {
		logic [7:0] intensity;
		logic       power_off;
		logic       fb_blanked;
	} lvl_t;

	typedef struct packed {
		logic [23:0] duty_ns;
		logic        pwm_on;
	} pwm_t;

	typedef enum logic [2:0] {
		CFG_RESUMED      = 3'd0,
		CFG_PANEL_SELECT = 3'd1,
		CFG_PERIOD_NS    = 3'd2,
		CFG_LOWER_OFFSET = 3'd3,
		CFG_MAX_LEVEL    = 3'd4
	} cfg_idx_t;

	localparam int          CFG_W        = 24;
	localparam int          CURVE_LEN    = 35;
	localparam logic [7:0]  DIM_LIMIT    = 8'd10;
	localparam logic [7:0]  DIM_LEVEL    = 8'd10;
	localparam logic [7:0]  TOP_REQUEST  = 8'd255;
	localparam logic [23:0] RST_PERIOD   = 24'd1000000;
	localparam logic [23:0] RST_OFFSET   = 24'd0;
	localparam logic [7:0]  RST_MAX_LVL  = 8'd255;
	localparam logic [23:0] DUTY_MAX     = 24'hFFFFFF;

	// divider: 32-bit dividend, 8-bit divisor, four quotient bits per stage
	localparam int DIV_STAGES = 8;
	localparam int DIV_STEP   = 4;

	localparam logic [7:0] CURVE_STEP [CURVE_LEN] = '{
		8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd80, 8'd90, 8'd100,
		8'd110, 8'd120, 8'd130, 8'd140, 8'd150, 8'd160, 8'd165, 8'd170, 8'd175,
		8'd180, 8'd185, 8'd190, 8'd195, 8'd200, 8'd205, 8'd210, 8'd215, 8'd220,
		8'd225, 8'd230, 8'd235, 8'd240, 8'd245, 8'd250, 8'd255
	};

	localparam logic [7:0] CURVE_TUNE [2][CURVE_LEN] = '{
		'{8'd7, 8'd10, 8'd16, 8'd22, 8'd28, 8'd35, 8'd40, 8'd45, 8'd50, 8'd55,
		  8'd60, 8'd65, 8'd72, 8'd78, 8'd85, 8'd92, 8'd98, 8'd104, 8'd110,
		  8'd115, 8'd120, 8'd125, 8'd130, 8'd135, 8'd140, 8'd145, 8'd150,
		  8'd155, 8'd160, 8'd165, 8'd170, 8'd175, 8'd181, 8'd187, 8'd193},
		'{8'd16, 8'd22, 8'd28, 8'd35, 8'd40, 8'd45, 8'd50, 8'd55, 8'd60, 8'd65,
		  8'd72, 8'd78, 8'd85, 8'd92, 8'd98, 8'd104, 8'd110, 8'd115, 8'd120,
		  8'd125, 8'd130, 8'd135, 8'd140, 8'd145, 8'd150, 8'd155, 8'd160,
		  8'd165, 8'd170, 8'd175, 8'd181, 8'd187, 8'd193, 8'd199, 8'd205}
	};

endpackage

// ----- rtl/backlight_level_to_pwm_duty.sv -----
// ----------------------------------------------------------------------------
// backlight_level_to_pwm_duty
// maps a brightness request through a tuned curve and scales it to a pwm
// on-time: lookup, multiply, eight-stage divide, offset add and saturate
// ----------------------------------------------------------------------------
//   channel   direction   handshake              payload
//   lvl       in          lvl_valid / lvl_stall  intensity, power_off, fb_blanked
//   pwm       out         pwm_valid / pwm_stall  duty_ns, pwm_on
//   cfg       in          cfg_we                 cfg_idx, cfg_data
//
// one beat per cycle while pwm is not stalled; eleven register stages (lookup,
// multiply, the eight radix-16 divider stages and the output register) lie
// between a beat's accepting edge and its result on pwm. reset loads register
// defaults and empties the pipeline.
// a stalled result beat freezes every stage and raises lvl_stall; a beat is
// dropped only if it is accepted while resumed is clear.
// ----------------------------------------------------------------------------
module backlight_level_to_pwm_duty #(
	parameter int TABLE_ENTRIES = 35
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  lvl_valid,
	output logic                  lvl_stall,
	input  blpd_pkg::lvl_t        lvl,
	output logic                  pwm_valid,
	input  logic                  pwm_stall,
	output blpd_pkg::pwm_t        pwm,
	input  logic                  cfg_we,
	input  blpd_pkg::cfg_idx_t    cfg_idx,
	input  logic [blpd_pkg::CFG_W-1:0] cfg_data
);
	import blpd_pkg::*;

	localparam int NUSED = (TABLE_ENTRIES > CURVE_LEN) ? CURVE_LEN :
		((TABLE_ENTRIES < 1) ? 1 : TABLE_ENTRIES);
	localparam int LAST = NUSED - 1;

	logic        resumed_q;
	logic        panel_sel_q;
	logic [23:0] period_q;
	logic [23:0] offset_q;
	logic [7:0]  max_lvl_q;

	logic        adv;
	logic [7:0]  level_nx;
	logic [23:0] span_nx;
	logic [7:0]  divisor;

	logic        vld_s1;
	logic        zero_s1;
	logic [7:0]  level_s1;
	logic [23:0] span_s1;

	logic        vld_s2;
	logic        zero_s2;
	logic [31:0] prod_s2;

	logic        vld_s  [DIV_STAGES];
	logic        zero_s [DIV_STAGES];
	logic [31:0] num_s  [DIV_STAGES];
	logic [7:0]  rem_s  [DIV_STAGES];
	logic [31:0] num_nx [DIV_STAGES];
	logic [7:0]  rem_nx [DIV_STAGES];

	logic [32:0] sum;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resumed_q   <= 1'b1;
			panel_sel_q <= 1'b0;
			period_q    <= RST_PERIOD;
			offset_q    <= RST_OFFSET;
			max_lvl_q   <= RST_MAX_LVL;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_RESUMED:      resumed_q   <= cfg_data[0];
				CFG_PANEL_SELECT: panel_sel_q <= cfg_data[0];
				CFG_PERIOD_NS:    period_q    <= cfg_data;
				CFG_LOWER_OFFSET: offset_q    <= cfg_data;
				CFG_MAX_LEVEL:    max_lvl_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign adv       = !pwm_valid || !pwm_stall;
	assign lvl_stall = !adv;
	assign divisor   = (max_lvl_q == 8'd0) ? 8'd1 : max_lvl_q;

	// curve lookup
	always_comb begin
		level_nx = lvl.intensity;
		for (int i = CURVE_LEN - 1; i >= 0; i--) begin
			if (i < NUSED && lvl.intensity <= CURVE_STEP[i])
				level_nx = CURVE_TUNE[panel_sel_q][i];
		end
		if (lvl.intensity == TOP_REQUEST)
			level_nx = CURVE_TUNE[panel_sel_q][LAST];
		if (lvl.intensity < DIM_LIMIT)
			level_nx = DIM_LEVEL;
	end

	assign span_nx = (offset_q < period_q) ? (period_q - offset_q) : 24'd0;

	// restoring division, DIV_STEP quotient bits per stage
	always_comb begin
		logic [31:0] t_num;
		logic [7:0]  t_rem;
		logic [8:0]  t_r9;
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (k == 0) begin
				t_num = prod_s2;
				t_rem = 8'd0;
			end else begin
				t_num = num_s[k-1];
				t_rem = rem_s[k-1];
			end
			for (int b = 0; b < DIV_STEP; b++) begin
				t_r9  = {t_rem, t_num[31]};
				t_num = {t_num[30:0], 1'b0};
				if (t_r9 >= {1'b0, divisor}) begin
					t_r9     = t_r9 - {1'b0, divisor};
					t_num[0] = 1'b1;
				end
				t_rem = t_r9[7:0];
			end
			num_nx[k] = t_num;
			rem_nx[k] = t_rem;
		end
	end

	assign sum = {9'd0, offset_q} + {1'b0, num_s[DIV_STAGES-1]};

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			pwm_valid <= 1'b0;
			for (int k = 0; k < DIV_STAGES; k++)
				vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s1   <= lvl_valid && resumed_q;
			vld_s2   <= vld_s1;
			vld_s[0] <= vld_s2;
			for (int k = 1; k < DIV_STAGES; k++)
				vld_s[k] <= vld_s[k-1];
			pwm_valid <= vld_s[DIV_STAGES-1];
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s1  <= lvl.power_off || lvl.fb_blanked || (lvl.intensity == 8'd0);
			level_s1 <= level_nx;
			span_s1  <= span_nx;

			zero_s2 <= zero_s1;
			prod_s2 <= 32'(level_s1) * 32'(span_s1);

			zero_s[0] <= zero_s2;
			for (int k = 1; k < DIV_STAGES; k++)
				zero_s[k] <= zero_s[k-1];
			for (int k = 0; k < DIV_STAGES; k++) begin
				num_s[k] <= num_nx[k];
				rem_s[k] <= rem_nx[k];
			end

			if (zero_s[DIV_STAGES-1]) begin
				pwm.duty_ns <= 24'd0;
				pwm.pwm_on  <= 1'b0;
			end else begin
				pwm.duty_ns <= (sum[32:24] != 9'd0) ? DUTY_MAX : sum[23:0];
				pwm.pwm_on  <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/blpd_chk.sv -----
// ----------------------------------------------------------------------------
// blpd_chk
// port-level checks for the backlight duty block, bound to the top level
// ----------------------------------------------------------------------------
`include "backlight_level_to_pwm_duty_assert.svh"

module blpd_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       lvl_valid,
	input logic                       lvl_stall,
	input blpd_pkg::lvl_t             lvl,
	input logic                       pwm_valid,
	input logic                       pwm_stall,
	input blpd_pkg::pwm_t             pwm,
	input logic                       cfg_we,
	input blpd_pkg::cfg_idx_t         cfg_idx,
	input logic [blpd_pkg::CFG_W-1:0] cfg_data
);
	import blpd_pkg::*;

	// a stalled result beat holds
	`BLPD_AST_NXT(a_pwm_hold, pwm_valid && pwm_stall, pwm_valid && $stable(pwm))
	// a disabled pwm always carries zero on-time
	`BLPD_AST_NOW(a_off_zero, pwm_valid && !pwm.pwm_on, pwm.duty_ns == 24'd0)
	// input back-pressure only comes from a held output beat
	`BLPD_AST_NOW(a_stall_src, lvl_stall, pwm_valid && pwm_stall)

endmodule

bind backlight_level_to_pwm_duty blpd_chk u_blpd_chk (.*);
